### src/sfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the slot allocator: operation and status codes, controller states,
// the command and status bundles between controller and datapath, and default sizes.
// No dependencies.
package sfl_pkg;

    localparam int HANDLE_W       = 10;
    localparam int FUNC_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int ENTRIES_DEF    = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_STORE   = 2'd0,
        FN_DISPOSE = 2'd1,
        FN_READ    = 2'd2,
        FN_PROBE   = 2'd3
    } sfl_func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BEYOND = 2'd2,
        ST_UNUSED = 2'd3
    } sfl_status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } sfl_state_t;

    typedef struct packed {
        logic accept;
        logic commit;
    } sfl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } sfl_stat_t;

endpackage : sfl_pkg
`default_nettype wire

### src/sfl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sfl_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : sfl_ram
`default_nettype wire

### src/sfl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Controller of the slot allocator: a two-state machine that takes one beat,
// then commits it once the output register can take the result.
// Depends on sfl_pkg.
module sfl_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire sfl_pkg::sfl_stat_t stat,
    output sfl_pkg::sfl_cmd_t     cmd
);

    sfl_pkg::sfl_state_t state_reg;
    sfl_pkg::sfl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfl_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfl_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = sfl_pkg::S_EXEC;
                end
            end
            sfl_pkg::S_EXEC:
            begin
                if (!stat.out_busy)
                begin
                    state_next = sfl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sfl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            sfl_pkg::S_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            sfl_pkg::S_EXEC:
            begin
                cmd.commit = !stat.out_busy;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule : sfl_ctrl
`default_nettype wire

### src/sfl_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// Datapath of the slot allocator: input latch, free-list head, counters, the entry
// RAM (allocation bit kept beside the data) and the output register.
// Depends on sfl_pkg and sfl_ram.
module sfl_datapath #(
    parameter int ENTRIES    = sfl_pkg::ENTRIES_DEF,
    parameter int DATA_WIDTH = sfl_pkg::DATA_WIDTH_DEF,
    parameter int TD_W       = ((sfl_pkg::HANDLE_W + DATA_WIDTH + 7) / 8) * 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire sfl_pkg::sfl_cmd_t            cmd,
    output sfl_pkg::sfl_stat_t                stat,
    input  wire logic [TD_W-1:0]              s_tdata,
    input  wire logic [sfl_pkg::FUNC_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [TD_W-1:0]              m_tdata,
    output logic      [sfl_pkg::STATUS_W:0]   m_tuser
);

    localparam int AW    = $clog2(ENTRIES);
    localparam int CNT_W = AW + 1;
    localparam int HW    = sfl_pkg::HANDLE_W;
    localparam int CMP_W = (CNT_W > HW) ? CNT_W : HW;
    localparam int RAM_W = DATA_WIDTH + 1;

    sfl_pkg::sfl_func_t   func_reg;
    logic [HW-1:0]         handle_reg;
    logic [DATA_WIDTH-1:0] data_reg;

    logic [AW-1:0]    free_head_reg, free_head_next;
    logic [CNT_W-1:0] free_count_reg, free_count_next;
    logic [CNT_W-1:0] high_water_reg, high_water_next;

    logic                   m_tvalid_reg;
    logic [HW-1:0]          out_handle_reg, out_handle_next;
    logic [DATA_WIDTH-1:0]  out_data_reg, out_data_next;
    logic                   allocated_reg, allocated_next;
    sfl_pkg::sfl_status_t   status_reg, status_next;

    sfl_pkg::sfl_func_t    in_func;
    logic [AW-1:0]         rd_addr;
    logic [RAM_W-1:0]      rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [RAM_W-1:0]      wr_data;
    logic                  slot_alloc;
    logic [DATA_WIDTH-1:0] slot_data;
    logic [AW-1:0]         handle_idx;
    logic                  beyond;

    assign in_func    = sfl_pkg::sfl_func_t'(s_tuser);
    assign handle_idx = AW'(handle_reg);
    assign slot_alloc = rd_data[DATA_WIDTH];
    assign slot_data  = rd_data[DATA_WIDTH-1:0];
    assign beyond     = CMP_W'(handle_reg) >= CMP_W'(high_water_reg);

    // A store reads the free-list head so the next link is known at commit.
    assign rd_addr = (in_func == sfl_pkg::FN_STORE) ? free_head_reg : AW'(s_tdata[HW-1:0]);

    sfl_ram #(
        .WIDTH(RAM_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (cmd.accept),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg   <= in_func;
            handle_reg <= s_tdata[HW-1:0];
            data_reg   <= s_tdata[HW+DATA_WIDTH-1:HW];
        end
        if (cmd.commit)
        begin
            out_handle_reg <= out_handle_next;
            out_data_reg   <= out_data_next;
            allocated_reg  <= allocated_next;
            status_reg     <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg  <= '0;
            free_count_reg <= '0;
            high_water_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                free_head_reg  <= free_head_next;
                free_count_reg <= free_count_next;
                high_water_reg <= high_water_next;
            end
            if (cmd.commit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        high_water_next = high_water_reg;
        out_handle_next = handle_reg;
        out_data_next   = '0;
        allocated_next  = 1'b0;
        status_next     = sfl_pkg::ST_OK;
        wr_en           = 1'b0;
        wr_addr         = handle_idx;
        wr_data         = {1'b1, data_reg};
        case (func_reg)
            sfl_pkg::FN_STORE:
            begin
                if (free_count_reg != '0)
                begin
                    // Reuse the most recently freed slot; its entry holds the next link.
                    wr_en           = cmd.commit;
                    wr_addr         = free_head_reg;
                    free_count_next = free_count_reg - CNT_W'(1);
                    free_head_next  = (free_count_next != '0) ? AW'(slot_data) : '0;
                    out_handle_next = HW'(free_head_reg);
                    allocated_next  = 1'b1;
                end
                else if (high_water_reg == CNT_W'(ENTRIES))
                begin
                    status_next = sfl_pkg::ST_FULL;
                end
                else
                begin
                    wr_en           = cmd.commit;
                    wr_addr         = AW'(high_water_reg);
                    high_water_next = high_water_reg + CNT_W'(1);
                    out_handle_next = HW'(high_water_reg);
                    allocated_next  = 1'b1;
                end
            end
            sfl_pkg::FN_DISPOSE:
            begin
                if (beyond)
                begin
                    status_next = sfl_pkg::ST_BEYOND;
                end
                else if (!slot_alloc)
                begin
                    status_next = sfl_pkg::ST_UNUSED;
                end
                else
                begin
                    // The freed entry takes the old head, or all ones as the end mark.
                    wr_en = cmd.commit;
                    if (free_count_reg == '0)
                    begin
                        wr_data = {1'b0, {DATA_WIDTH{1'b1}}};
                    end
                    else
                    begin
                        wr_data = {1'b0, DATA_WIDTH'(free_head_reg)};
                    end
                    free_head_next  = handle_idx;
                    free_count_next = free_count_reg + CNT_W'(1);
                end
            end
            sfl_pkg::FN_READ:
            begin
                if (beyond)
                begin
                    status_next = sfl_pkg::ST_BEYOND;
                end
                else if (!slot_alloc)
                begin
                    status_next = sfl_pkg::ST_UNUSED;
                end
                else
                begin
                    out_data_next  = slot_data;
                    allocated_next = 1'b1;
                end
            end
            sfl_pkg::FN_PROBE:
            begin
                if (beyond)
                begin
                    status_next = sfl_pkg::ST_BEYOND;
                end
                else
                begin
                    out_data_next  = slot_data;
                    allocated_next = slot_alloc;
                end
            end
            default:
            begin
                status_next = sfl_pkg::ST_OK;
            end
        endcase
    end

    assign stat.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = TD_W'({out_data_reg, out_handle_reg});
    assign m_tuser       = {status_reg, allocated_reg};

endmodule : sfl_datapath
`default_nettype wire

### src/slot_allocator_free_list.sv
`timescale 1ns / 1ps
`default_nettype none
// Slot allocator with a last-in, first-out free list and a per-entry allocation bit.
// Depends on sfl_pkg, sfl_ctrl and sfl_datapath.
//
// Usage:
// One beat on the slave side carries one operation (store, dispose, read or probe);
// each gives exactly one result beat on the master side, with the handle, the
// entry data, the allocation bit and a status code.
// In an operation, the accepting cycle starts the entry RAM read
// (the free-list head for a store, the handle otherwise), and the commit cycle
// uses the registered read data, writes the RAM and loads the output register.
// Since the write follows the registered RAM read, the block takes no new beat
// until the current one has committed its result to the output register.
// The output register lets a new beat be taken while a result waits.
// When the receiver stalls and a result is still held, the block holds the next
// operation in its commit cycle until the output register frees up.
// Reset clears the free list, the counters and the output valid; the entry RAM
// needs no clearing pass, since only slots below the high-water mark are read.
module slot_allocator_free_list #(
    parameter int ENTRIES    = sfl_pkg::ENTRIES_DEF,
    parameter int DATA_WIDTH = sfl_pkg::DATA_WIDTH_DEF,
    parameter int TD_W       = ((sfl_pkg::HANDLE_W + DATA_WIDTH + 7) / 8) * 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [TD_W-1:0]            s_tdata,  // handle, data, zero padding
    input  wire logic [sfl_pkg::FUNC_W-1:0] s_tuser,  // func
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [TD_W-1:0]            m_tdata,  // out_handle, out_data, zero padding
    output logic      [sfl_pkg::STATUS_W:0] m_tuser   // allocated, status
);

    sfl_pkg::sfl_cmd_t  cmd;
    sfl_pkg::sfl_stat_t stat;

    sfl_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sfl_datapath #(
        .ENTRIES   (ENTRIES),
        .DATA_WIDTH(DATA_WIDTH),
        .TD_W      (TD_W)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // Only one operation is in flight: a beat taken is never followed by another
    // in the next cycle.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("beat accepted while an operation was in flight");

    // A commit always presents a result beat in the following cycle.
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid)
        else $error("committed result missing on the output");

    // Commit never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(m_tvalid && !m_tready))
        else $error("result overwritten while stalled");

    // A failing operation never reports the slot as allocated.
    a_error_unalloc: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[sfl_pkg::STATUS_W:1] != sfl_pkg::ST_OK)) |-> !m_tuser[0])
        else $error("error result marked as allocated");

endmodule : slot_allocator_free_list
`default_nettype wire

### test/slot_allocator_free_list_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for slot_allocator_free_list: stream beats in, predicted replies out.
// Depends on sfl_pkg and the slot_allocator_free_list RTL with its submodules.
module slot_allocator_free_list_tb;
    import sfl_pkg::*;

    localparam int ENTRIES  = ENTRIES_DEF;
    localparam int DATA_W   = DATA_WIDTH_DEF;
    localparam int TD_W     = ((HANDLE_W + DATA_W + 7) / 8) * 8;
    localparam int PAD_W    = TD_W - HANDLE_W - DATA_W;
    localparam int LINK_W   = 16;
    localparam int CLK_HALF = 4;

    typedef struct {
        logic [HANDLE_W-1:0] hnd;
        logic [DATA_W-1:0]   dat;
        logic                alloc;
        sfl_status_t         st;
    } slot_reply_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TD_W-1:0]     s_tdata = '0;    // handle, data, zero padding
    logic [FUNC_W-1:0]   s_tuser = '0;    // func
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TD_W-1:0]     m_tdata;         // out_handle, out_data, zero padding
    logic [STATUS_W:0]   m_tuser;         // allocated, status

    // Shadow copy of the allocator state.
    logic [DATA_W-1:0] slot_mem [ENTRIES];
    bit                slot_used [ENTRIES];
    int unsigned       free_top = 0;
    int unsigned       free_cnt = 0;
    int unsigned       high_water_mark = 0;

    slot_reply_t replies_due[$];
    int          fail_count = 0;

    // Sender burst control.
    bit sender_idles = 1'b0;
    int burst_left = 0;

    // Receiver stall pattern and long hold-off.
    bit          receiver_stalls = 1'b0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_phase = 0;
    int          hold_request = 0;
    int          hold_left = 0;

    slot_allocator_free_list uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF clk = ~clk;

    function automatic slot_reply_t apply_slot_op(input sfl_func_t f,
                                                  input logic [HANDLE_W-1:0] h,
                                                  input logic [DATA_W-1:0] d);
        slot_reply_t       r;
        int unsigned       slot;
        logic [DATA_W-1:0] link;
        r.hnd   = h;
        r.dat   = '0;
        r.alloc = 1'b0;
        r.st    = ST_OK;
        if (f == FN_STORE)
        begin
            if (free_cnt > 0 && free_top < ENTRIES)
            begin
                slot = free_top;
                link = slot_mem[slot];
                free_cnt--;
                free_top = (free_cnt > 0) ? int'(link[LINK_W-1:0]) : 0;
                slot_mem[slot]  = d;
                slot_used[slot] = 1'b1;
                r.hnd   = HANDLE_W'(slot);
                r.alloc = 1'b1;
            end
            else if (high_water_mark >= ENTRIES)
            begin
                r.st = ST_FULL;
            end
            else
            begin
                slot = high_water_mark;
                slot_mem[slot]  = d;
                slot_used[slot] = 1'b1;
                high_water_mark++;
                r.hnd   = HANDLE_W'(slot);
                r.alloc = 1'b1;
            end
        end
        else if (h >= high_water_mark)
        begin
            r.st = ST_BEYOND;
        end
        else if (f == FN_PROBE)
        begin
            r.dat   = slot_mem[h];
            r.alloc = slot_used[h];
        end
        else if (!slot_used[h])
        begin
            r.st = ST_UNUSED;
        end
        else if (f == FN_READ)
        begin
            r.dat   = slot_mem[h];
            r.alloc = 1'b1;
        end
        else
        begin
            // The freed entry holds the old list head; the tail holds all ones.
            slot_used[h] = 1'b0;
            slot_mem[h]  = (free_cnt == 0) ? '1 : DATA_W'(free_top);
            free_top     = h;
            free_cnt++;
        end
        return r;
    endfunction

    task automatic send_op(input sfl_func_t f, input logic [HANDLE_W-1:0] h,
                           input logic [DATA_W-1:0] d);
        s_tuser  <= f;
        s_tdata  <= {{PAD_W{1'b0}}, d, h};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        replies_due.push_back(apply_slot_op(f, h, d));
        if (sender_idles)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // Mostly handles below the high-water mark, so that operations get past the range check.
    task automatic send_random_op(input int store_pct);
        int                  pick;
        sfl_func_t           f;
        logic [HANDLE_W-1:0] h;
        pick = $urandom_range(99);
        if (pick < store_pct)
            f = FN_STORE;
        else if (pick < store_pct + (100 - store_pct) * 4 / 10)
            f = FN_DISPOSE;
        else if (pick < store_pct + (100 - store_pct) * 7 / 10)
            f = FN_READ;
        else
            f = FN_PROBE;
        if (high_water_mark > 0 && $urandom_range(9) != 0)
            h = HANDLE_W'($urandom_range(high_water_mark - 1));
        else
            h = HANDLE_W'($urandom_range(ENTRIES - 1));
        send_op(f, h, DATA_W'($urandom));
    endtask

    task automatic test_directed_cases();
        send_op(FN_PROBE, 10'd0, 32'h0);             // nothing allocated yet
        send_op(FN_READ, 10'd0, 32'hFFFF_FFFF);
        send_op(FN_DISPOSE, 10'd1023, 32'h0);
        send_op(FN_STORE, 10'd1023, 32'h0000_0000);
        send_op(FN_STORE, 10'd0, 32'hFFFF_FFFF);
        send_op(FN_STORE, 10'h155, 32'hA5A5_A5A5);
        send_op(FN_STORE, 10'h2AA, 32'h5A5A_5A5A);
        send_op(FN_READ, 10'd0, 32'h0);
        send_op(FN_READ, 10'd1, 32'h0);
        send_op(FN_PROBE, 10'd3, 32'h0);
        send_op(FN_DISPOSE, 10'd1, 32'h0);           // empty list: link becomes the end mark
        send_op(FN_PROBE, 10'd1, 32'h0);
        send_op(FN_READ, 10'd1, 32'h0);
        send_op(FN_DISPOSE, 10'd1, 32'h0);
        send_op(FN_DISPOSE, 10'd2, 32'h0);
        send_op(FN_PROBE, 10'd2, 32'h0);
        send_op(FN_PROBE, 10'd4, 32'h0);
        send_op(FN_STORE, 10'd0, 32'h1234_5678);     // reuses slot 2
        send_op(FN_STORE, 10'd0, 32'h8765_4321);     // reuses the last free slot
        send_op(FN_STORE, 10'd0, 32'hDEAD_BEEF);
        send_op(FN_READ, 10'd2, 32'h0);
        send_op(FN_READ, 10'd1, 32'h0);
    endtask

    task automatic test_random_traffic();
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        repeat (60) send_random_op(40);
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        repeat (40) send_random_op(40);
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        repeat (100) send_random_op(60);
    endtask

    task automatic test_output_backpressure();
        sender_idles = 1'b0;
        hold_request = 120;
        repeat (20) send_random_op(50);
        sender_idles = 1'b1;
    endtask

    task automatic test_fill_to_capacity();
        while (!(free_cnt == 0 && high_water_mark == ENTRIES))
            send_op(FN_STORE, HANDLE_W'($urandom), DATA_W'($urandom));
        send_op(FN_STORE, 10'd0, 32'h0);
        send_op(FN_STORE, 10'd1023, 32'hFFFF_FFFF);
        send_op(FN_STORE, HANDLE_W'($urandom), DATA_W'($urandom));
        send_op(FN_DISPOSE, 10'd1023, 32'h0);
        send_op(FN_DISPOSE, 10'd0, 32'h0);
        send_op(FN_DISPOSE, 10'd512, 32'h0);
        send_op(FN_PROBE, 10'd1023, 32'h0);
        send_op(FN_PROBE, 10'd0, 32'h0);
        send_op(FN_PROBE, 10'd512, 32'h0);
        repeat (3) send_op(FN_STORE, 10'd0, DATA_W'($urandom));
        send_op(FN_STORE, 10'd1023, 32'h0);
        send_op(FN_READ, 10'd1023, 32'h0);
        repeat (30) send_random_op(55);
    endtask

    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ready_pattern[pattern_phase];
            if (pattern_phase == 15)
            begin
                pattern_phase = 0;
                ready_pattern = receiver_stalls ? 16'($urandom | $urandom) : 16'hFFFF;
            end
            else
            begin
                pattern_phase++;
            end
        end
    end

    always @(posedge clk)
    begin : check_replies
        slot_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("reply beat with no operation outstanding: handle %0d status %0d",
                       m_tdata[HANDLE_W-1:0], m_tuser[STATUS_W:1]);
                fail_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (m_tdata[HANDLE_W-1:0] !== want.hnd)
                begin
                    $error("out_handle: expected %0d, got %0d", want.hnd, m_tdata[HANDLE_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[HANDLE_W +: DATA_W] !== want.dat)
                begin
                    $error("out_data: expected %h, got %h", want.dat, m_tdata[HANDLE_W +: DATA_W]);
                    fail_count++;
                end
                if (m_tdata[TD_W-1 -: PAD_W] !== '0)
                begin
                    $error("padding: expected 0, got %h", m_tdata[TD_W-1 -: PAD_W]);
                    fail_count++;
                end
                if (m_tuser[0] !== want.alloc)
                begin
                    $error("allocated: expected %0d, got %0d", want.alloc, m_tuser[0]);
                    fail_count++;
                end
                if (m_tuser[STATUS_W:1] !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, m_tuser[STATUS_W:1]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : run_tests
        int wait_cycles;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_traffic();
        test_output_backpressure();
        test_fill_to_capacity();
        s_tvalid <= 1'b0;
        receiver_stalls = 1'b0;
        wait_cycles = 0;
        while (replies_due.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (replies_due.size() != 0)
        begin
            $error("%0d replies never arrived", replies_due.size());
            fail_count++;
        end
        // Keep clocking to catch any stray reply beats.
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
